/* rtl/stg_pkg.sv */
package stg_pkg;

  localparam int TABLE_ADDR_BITS = 10;
  localparam int SINE_BITS       = 24;

  localparam int TABLE_SIZE  = (1 << TABLE_ADDR_BITS) + 1;
  localparam int ROM_IDX_W   = TABLE_ADDR_BITS + 1;
  localparam int MAG_W       = SINE_BITS - 1;
  localparam int GAIN_W      = 20;
  localparam int PROD_W      = MAG_W + GAIN_W;
  localparam int SCALE_SHIFT = SINE_BITS + 15;
  localparam int MAGC_W      = SCALE_SHIFT + 1;
  localparam int PCM16_SHIFT = 15;
  localparam int PCM32_SHIFT = 31;
  localparam int PCM8_SHIFT  = 7;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
  localparam logic [1:0] REG_PHASE_OFFSET = 2'd1;
  localparam logic [1:0] REG_GAIN         = 2'd2;
  localparam logic [1:0] REG_OUT_FORMAT   = 2'd3;

  localparam logic [1:0] FMT_S16 = 2'd0;
  localparam logic [1:0] FMT_S32 = 2'd1;
  localparam logic [1:0] FMT_U8  = 2'd2;

  localparam logic [31:0]       RST_PHASE_STEP   = 32'd89478485;
  localparam logic [31:0]       RST_PHASE_OFFSET = 32'd0;
  localparam logic [GAIN_W-1:0] RST_GAIN         = GAIN_W'(65536);
  localparam logic [1:0]        RST_OUT_FORMAT   = FMT_S16;

  typedef struct packed {
    logic [31:0]       phase_step;
    logic [31:0]       phase_offset;
    logic [GAIN_W-1:0] gain;
    logic [1:0]        out_format;
  } cfg_t;

  typedef struct packed {
    logic load_phase;
    logic load_addr;
    logic load_rom;
    logic load_mul;
    logic load_clamp;
    logic load_scale;
    logic load_out;
  } dp_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_ROM,
    ST_MUL,
    ST_CLAMP,
    ST_SCALE,
    ST_DONE
  } ctrl_state_e;

  typedef logic [MAG_W-1:0] sine_rom_t [TABLE_SIZE];

  // shift and subtract quotient, used only while building the table
  function automatic longint unsigned udiv_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave table, Q30 Taylor series with truncation, evaluated at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned full;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned v;
    longint unsigned den;
    full = (64'd1 << (SINE_BITS - 1)) - 64'd1;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      x    = (64'(k) * PI_HALF_Q30) >> TABLE_ADDR_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 7; n++) begin
        den  = 64'((2 * n) * (2 * n + 1));
        term = udiv_u64((term * x2) >> 30, den);
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum * full + (64'd1 << 29)) >> 30;
      if (v > full) begin
        v = full;
      end
      rom[k] = MAG_W'(v);
    end
    return rom;
  endfunction

endpackage

/* rtl/sine_tone_generator_top.sv */
// Sine tone generator (DDS). Each accepted item yields one PCM sample: the
// 32-bit phase accumulator (cleared first when restart is set) plus the phase
// offset addresses a quarter-wave sine ROM, the value is scaled by the Q4.16
// gain, clamped to full scale and converted to the selected PCM format. An
// item goes through the steps accept and phase step, table address, ROM read,
// gain multiply, clamp, PCM conversion, output load; the sequencer handles one item
// at a time through the single datapath. A finished sample waits in the output
// register while the next item is taken. Registers via APB at byte address
// 4*i: phase_step, phase_offset, gain, output_format; write only while idle.
module sine_tone_generator_top
  import stg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [31:0]    sample_o,
  output logic                  clipped_o
);

  cfg_t    cfg;
  dp_cmd_t cmd;

  stg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  stg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  stg_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cfg_i     (cfg),
    .restart_i (restart_i),
    .sample_o  (sample_o),
    .clipped_o (clipped_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again while an item is in progress");

  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("sequencer not idle after loading a result");

  a_fmt_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && (paddr[3:2] == REG_OUT_FORMAT))
      |=> (cfg.out_format == $past(pwdata[1:0])))
    else $error("output format register write lost");

endmodule

/* rtl/stg_regs.sv */
module stg_regs
  import stg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_PHASE_STEP:   cfg_d.phase_step   = pwdata;
        REG_PHASE_OFFSET: cfg_d.phase_offset = pwdata;
        REG_GAIN:         cfg_d.gain         = pwdata[GAIN_W-1:0];
        REG_OUT_FORMAT:   cfg_d.out_format   = pwdata[1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step   <= RST_PHASE_STEP;
      cfg_q.phase_offset <= RST_PHASE_OFFSET;
      cfg_q.gain         <= RST_GAIN;
      cfg_q.out_format   <= RST_OUT_FORMAT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PHASE_STEP:   prdata = cfg_q.phase_step;
      REG_PHASE_OFFSET: prdata = cfg_q.phase_offset;
      REG_GAIN:         prdata = APB_DATA_W'(cfg_q.gain);
      REG_OUT_FORMAT:   prdata = APB_DATA_W'(cfg_q.out_format);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/stg_ctrl.sv */
module stg_ctrl
  import stg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q;
  ctrl_state_e state_d;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_ROM;
      ST_ROM:   state_d = ST_MUL;
      ST_MUL:   state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_SCALE;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load_phase = in_valid_i;
      end
      ST_ADDR:  cmd_o.load_addr  = 1'b1;
      ST_ROM:   cmd_o.load_rom   = 1'b1;
      ST_MUL:   cmd_o.load_mul   = 1'b1;
      ST_CLAMP: cmd_o.load_clamp = 1'b1;
      ST_SCALE: cmd_o.load_scale = 1'b1;
      ST_DONE:  cmd_o.load_out   = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/stg_dp.sv */
module stg_dp
  import stg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  input  cfg_t               cfg_i,
  input  logic               restart_i,
  output logic signed [31:0] sample_o,
  output logic               clipped_o
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'(64'd1 << SCALE_SHIFT);

  logic [31:0]           acc_q;
  logic [31:0]           acc_base;
  logic [31:0]           phase_q;
  logic [1:0]            quad;
  logic [ROM_IDX_W-1:0]  addr_lo;
  logic [ROM_IDX_W-1:0]  addr_d;
  logic [ROM_IDX_W-1:0]  addr_q;
  logic                  neg_q;
  logic [MAG_W-1:0]      rom_q;
  logic [PROD_W-1:0]     prod_q;
  logic [MAGC_W-1:0]     mag_q;
  logic                  clip_q;
  logic [MAGC_W+PCM16_SHIFT-1:0] p16;
  logic [MAGC_W+PCM32_SHIFT-1:0] p32;
  logic [MAGC_W+PCM32_SHIFT-1:0] p32n;
  logic [MAGC_W+PCM8_SHIFT-1:0]  p8;
  logic [31:0]           q16;
  logic [31:0]           q32;
  logic [31:0]           q8;
  logic signed [31:0]    res_d;
  logic signed [31:0]    res_q;
  logic signed [31:0]    sample_q;
  logic                  clipped_q;

  assign acc_base = restart_i ? 32'd0 : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.load_phase) begin
      acc_q <= acc_base + cfg_i.phase_step;
    end
  end

  // quadrant from the top two phase bits, odd quadrants mirror the address
  assign quad    = phase_q[31:30];
  assign addr_lo = {1'b0, phase_q[29 -: TABLE_ADDR_BITS]};
  assign addr_d  = quad[0] ? (ROM_IDX_W'(1 << TABLE_ADDR_BITS) - addr_lo) : addr_lo;

  always_comb begin
    p16  = {mag_q, PCM16_SHIFT'(0)} - (MAGC_W + PCM16_SHIFT)'(mag_q);
    p32  = {mag_q, PCM32_SHIFT'(0)} - (MAGC_W + PCM32_SHIFT)'(mag_q);
    p32n = {mag_q, PCM32_SHIFT'(0)};
    p8   = {mag_q, PCM8_SHIFT'(0)} - (MAGC_W + PCM8_SHIFT)'(mag_q);
    q16  = 32'(p16 >> SCALE_SHIFT);
    q32  = neg_q ? 32'(p32n >> SCALE_SHIFT) : 32'(p32 >> SCALE_SHIFT);
    q8   = 32'(p8 >> SCALE_SHIFT);
    if (neg_q && (p8[SCALE_SHIFT-1:0] != '0)) begin
      q8 = q8 + 32'd1;
    end
    case (cfg_i.out_format)
      FMT_S16: res_d = neg_q ? -$signed(q16) : $signed(q16);
      FMT_S32: res_d = neg_q ? -$signed(q32) : $signed(q32);
      FMT_U8:  res_d = neg_q ? $signed(32'd128 - q8) : $signed(32'd128 + q8);
      default: res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_phase) begin
      phase_q <= acc_base + cfg_i.phase_offset;
    end
    if (cmd_i.load_addr) begin
      addr_q <= addr_d;
      neg_q  <= quad[1];
    end
    if (cmd_i.load_rom) begin
      rom_q <= SINE_ROM[addr_q];
    end
    if (cmd_i.load_mul) begin
      prod_q <= PROD_W'(rom_q) * PROD_W'(cfg_i.gain);
    end
    if (cmd_i.load_clamp) begin
      clip_q <= prod_q > FULL_SCALE;
      mag_q  <= (prod_q > FULL_SCALE) ? MAGC_W'(FULL_SCALE) : MAGC_W'(prod_q);
    end
    if (cmd_i.load_scale) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      sample_q  <= res_q;
      clipped_q <= clip_q;
    end
  end

  assign sample_o  = sample_q;
  assign clipped_o = clipped_q;

endmodule
